// File: rtl/ifed_pkg.sv
// ---------------------------------------------------------------------------
// ifed_pkg: shared definitions for the metadata TLV deframer
// Result record, result status codes, id map size and output queue sizing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ifed_pkg;

	// Size of the enabled-id map; only ids below both this and 32 can be known.
	localparam int ID_MAP_BITS = 32;
	localparam int ID_LIMIT    = (ID_MAP_BITS < 32) ? ID_MAP_BITS : 32;

	// Output queue depth and derived widths.
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

	// Result status codes.
	localparam logic [2:0] ST_KNOWN     = 3'd0;
	localparam logic [2:0] ST_UNKNOWN   = 3'd1;
	localparam logic [2:0] ST_MALFORMED = 3'd2;
	localparam logic [2:0] ST_TRUNCATED = 3'd3;
	localparam logic [2:0] ST_COMPLETE  = 3'd4;

	// One result transaction.
	typedef struct packed {
		logic [15:0] meta_id;
		logic [15:0] entry_length;
		logic [31:0] value_word;
		logic [2:0]  status;
		logic [31:0] unknown_total;
		logic        last_in_run;
	} result_t;

	// Results produced by one accepted byte, at most two.
	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} result_pair_t;

endpackage

// File: rtl/ifed_parser.sv
// ---------------------------------------------------------------------------
// ifed_parser: metadata TLV parser state and per-byte decode
// Holds the parser registers and the enabled-id register, and turns one
// accepted byte into up to two results in the same cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ifed_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [31:0]           cfg_wdata,
	input  logic                  accept,
	input  logic [7:0]            data_byte,
	input  logic                  first_byte,
	input  logic                  last_byte,
	output ifed_pkg::result_pair_t res
);

	localparam logic [2:0] PH_LEN_HI = 3'd0;
	localparam logic [2:0] PH_LEN_LO = 3'd1;
	localparam logic [2:0] PH_HDR    = 3'd2;
	localparam logic [2:0] PH_VALUE  = 3'd3;
	localparam logic [2:0] PH_IDLE   = 3'd4;

	logic [31:0] enabled_q;
	logic [2:0]  phase_q;
	logic [15:0] region_q, type_q, len_q, pos_q;
	logic [31:0] value_q, unknown_q;

	logic [2:0]  ph;
	logic [15:0] rl, et, el, ep, mlen, vi;
	logic [31:0] va, uc;
	logic        fin, known;
	logic        e1v, e2v, e3v;
	logic [15:0] e1_id, e1_len;
	logic [31:0] e1_val;
	logic [2:0]  e1_st;
	ifed_pkg::result_t e1, e2, e3;

	// Next state and results for the byte on the input.
	always_comb begin
		ph = phase_q;
		rl = region_q;
		et = type_q;
		el = len_q;
		ep = pos_q;
		va = value_q;
		uc = unknown_q;
		fin = 1'b0;
		known = 1'b0;
		e1v = 1'b0;
		e2v = 1'b0;
		e3v = 1'b0;
		e1_id = 16'd0;
		e1_len = 16'd0;
		e1_val = 32'd0;
		e1_st = ifed_pkg::ST_MALFORMED;
		mlen = 16'd0;
		vi = 16'd0;

		// A first byte restarts the parser at the length high byte.
		if (first_byte) begin
			ph = PH_LEN_HI;
			rl = 16'd0;
			et = 16'd0;
			el = 16'd0;
			ep = 16'd0;
			va = 32'd0;
		end

		unique case (ph)
			PH_LEN_HI: begin
				rl = {data_byte, 8'h00};
				ph = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				mlen = rl | {8'h00, data_byte};
				if (mlen < 16'd2) begin
					rl = 16'd0;
					e1v = 1'b1;
					e1_len = mlen;
					e1_st = ifed_pkg::ST_MALFORMED;
					ph = PH_IDLE;
				end else begin
					rl = mlen - 16'd2;
					et = 16'd0;
					el = 16'd0;
					ep = 16'd0;
					va = 32'd0;
					if (rl == 16'd0) begin
						e2v = 1'b1;
						ph = PH_IDLE;
					end else begin
						ph = PH_HDR;
					end
				end
			end
			PH_HDR: begin
				rl = rl - 16'd1;
				case (ep[1:0])
					2'd0: et = {data_byte, 8'h00};
					2'd1: et = et | {8'h00, data_byte};
					2'd2: el = {data_byte, 8'h00};
					default: el = el | {8'h00, data_byte};
				endcase
				ep = ep + 16'd1;
				if (ep >= 16'd4) begin
					if (el < 16'd4 || (el - 16'd4) > rl) begin
						e1v = 1'b1;
						e1_id = et;
						e1_len = el;
						e1_st = ifed_pkg::ST_MALFORMED;
						ph = PH_IDLE;
					end else if (el == 16'd4) begin
						fin = 1'b1;
					end else begin
						ph = PH_VALUE;
					end
				end else if (rl == 16'd0) begin
					e1v = 1'b1;
					e1_id = et;
					e1_len = el;
					e1_st = ifed_pkg::ST_MALFORMED;
					ph = PH_IDLE;
				end
			end
			PH_VALUE: begin
				vi = ep - 16'd4;
				rl = rl - 16'd1;
				if (vi < 16'd4) begin
					va = va | ({data_byte, 24'h000000} >> {vi[1:0], 3'b000});
				end
				ep = ep + 16'd1;
				if (ep == el) begin
					fin = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// Entry complete: report it, then close the region if it is used up.
		if (fin) begin
			known = (et < 16'(ifed_pkg::ID_LIMIT)) && enabled_q[et[4:0]];
			e1v = 1'b1;
			e1_id = et;
			e1_len = el;
			e1_val = va;
			if (known) begin
				e1_st = ifed_pkg::ST_KNOWN;
			end else begin
				e1_st = ifed_pkg::ST_UNKNOWN;
				uc = uc + 32'd1;
			end
			et = 16'd0;
			el = 16'd0;
			ep = 16'd0;
			va = 32'd0;
			if (rl == 16'd0) begin
				e2v = 1'b1;
				ph = PH_IDLE;
			end else begin
				ph = PH_HDR;
			end
		end

		// The frame ended while the region was still open.
		if (last_byte && ph != PH_IDLE) begin
			e3v = 1'b1;
			ph = PH_IDLE;
		end

		e1 = '{meta_id: e1_id, entry_length: e1_len, value_word: e1_val,
			status: e1_st, unknown_total: uc, last_in_run: 1'b0};
		e2 = '{meta_id: 16'd0, entry_length: 16'd0, value_word: 32'd0,
			status: ifed_pkg::ST_COMPLETE, unknown_total: uc, last_in_run: 1'b0};
		e3 = '{meta_id: 16'd0, entry_length: 16'd0, value_word: 32'd0,
			status: ifed_pkg::ST_TRUNCATED, unknown_total: uc, last_in_run: 1'b0};

		// Pack the results in order into two slots.
		res.v0 = e1v || e2v || e3v;
		res.v1 = e1v && (e2v || e3v);
		res.r0 = e1v ? e1 : (e2v ? e2 : e3);
		res.r1 = e2v ? e2 : e3;
		res.r0.last_in_run = !res.v1;
		res.r1.last_in_run = 1'b1;
	end

	// Enabled-id register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 32'd0;
		end else if (cfg_we) begin
			enabled_q <= cfg_wdata;
		end
	end

	// Parser state, updated on each accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LEN_HI;
			region_q  <= 16'd0;
			type_q    <= 16'd0;
			len_q     <= 16'd0;
			pos_q     <= 16'd0;
			value_q   <= 32'd0;
			unknown_q <= 32'd0;
		end else if (accept) begin
			phase_q   <= ph;
			region_q  <= rl;
			type_q    <= et;
			len_q     <= el;
			pos_q     <= ep;
			value_q   <= va;
			unknown_q <= uc;
		end
	end

endmodule

// File: rtl/ifed_out_queue.sv
// ---------------------------------------------------------------------------
// ifed_out_queue: result queue
// Takes up to two results per cycle and delivers one per cycle downstream while head_stall is low.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ifed_out_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  ifed_pkg::result_pair_t pair,
	output logic                   room,
	output logic                   head_valid,
	input  logic                   head_stall,
	output ifed_pkg::result_t      head
);

	ifed_pkg::result_t entries_q [ifed_pkg::Q_DEPTH];
	logic [ifed_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [ifed_pkg::Q_CNT_W-1:0] count_q;
	logic                         pop, push0, push1;
	logic [1:0]                   push_n;

	// Room for a full pair of results from the next byte.
	assign room       = count_q <= ifed_pkg::Q_CNT_W'(ifed_pkg::Q_DEPTH - 2);
	assign head_valid = count_q != '0;
	assign head       = entries_q[rd_ptr_q];
	assign pop        = head_valid && !head_stall;
	assign push0      = push && pair.v0;
	assign push1      = push && pair.v1;
	assign push_n     = {1'b0, push0} + {1'b0, push1};
	assign wr_ptr_p1  = wr_ptr_q + 1'b1;

	// Result storage.
	always_ff @(posedge clk) begin
		if (push0) begin
			entries_q[wr_ptr_q] <= pair.r0;
		end
		if (push1) begin
			entries_q[wr_ptr_p1] <= pair.r1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + ifed_pkg::Q_PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + ifed_pkg::Q_CNT_W'(push_n)
				- ifed_pkg::Q_CNT_W'(pop);
		end
	end

endmodule

// File: rtl/ife_metadata_tlv_deframer_top.sv
// ---------------------------------------------------------------------------
// ife_metadata_tlv_deframer_top: metadata TLV deframer
// Parses the metadata length and TLV entries following the outer Ethernet
// header and reports one result per entry plus region end and errors.
//
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_valid/cfg_ready  cfg_data (enabled_ids)
// in        in         in_valid/in_stall    data_byte, first_byte, last_byte
// out       out        out_valid/out_stall  meta_id .. last_in_run
//
// One byte is accepted per cycle while in_stall is low; its results are decided
// in that cycle and reach the output through a four-entry result queue that registers them.
// A byte that gives two results puts both into the queue, which drains one
// result per cycle while out_stall is low and so sets the sustained rate.
// in_stall rises when the queue cannot take two more results.
// Reset clears the parser, the enabled-id register and the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ife_metadata_tlv_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] meta_id,
	output logic [15:0] entry_length,
	output logic [31:0] value_word,
	output logic [2:0]  status,
	output logic [31:0] unknown_total,
	output logic        last_in_run
);

	ifed_pkg::result_pair_t pair;
	ifed_pkg::result_t      head;
	logic                   room, accept;

	// Input transaction is taken whenever the queue has room.
	assign cfg_ready = 1'b1;
	assign in_stall  = !room;
	assign accept    = in_valid && room;

	ifed_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid),
		.cfg_wdata  (cfg_data),
		.accept     (accept),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.res        (pair)
	);

	ifed_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.pair       (pair),
		.room       (room),
		.head_valid (out_valid),
		.head_stall (out_stall),
		.head       (head)
	);

	// Output payload from the queue head.
	assign meta_id       = head.meta_id;
	assign entry_length  = head.entry_length;
	assign value_word    = head.value_word;
	assign status        = head.status;
	assign unknown_total = head.unknown_total;
	assign last_in_run   = head.last_in_run;

endmodule

// File: dv/ife_metadata_tlv_deframer_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ife_metadata_tlv_deframer_top_tb: self-checking bench for the TLV deframer
// Feeds frame bytes as well-formed metadata regions, broken regions and
// noise. A scoreboard parses each accepted byte the way the block should and
// compares every result transaction field by field. Both sides idle and
// stall at random, and the enabled-id register is changed between phases.
// ---------------------------------------------------------------------------

class tlv_scoreboard;

	typedef enum logic [2:0] {
		P_LEN_HI,
		P_LEN_LO,
		P_HDR,
		P_VALUE,
		P_IDLE
	} parse_phase_e;

	// Results still owed by the block, oldest first.
	ifed_pkg::result_t want_q[$];
	// Results caused by the byte being parsed right now.
	ifed_pkg::result_t step_out[$];

	logic [31:0]  enables;
	parse_phase_e phase;
	logic [15:0]  region_left;
	logic [15:0]  etype;
	logic [15:0]  elen;
	logic [15:0]  epos;
	logic [31:0]  vacc;
	logic [31:0]  unknown_cnt;

	int unsigned parsed;
	int unsigned checked;
	int unsigned mismatches;
	int unsigned by_status[5];

	function new();
		enables     = '0;
		phase       = P_LEN_HI;
		region_left = '0;
		unknown_cnt = '0;
		parsed      = 0;
		checked     = 0;
		mismatches  = 0;
		foreach (by_status[i]) by_status[i] = 0;
		clear_entry();
	endfunction

	function void clear_entry();
		etype = '0;
		elen  = '0;
		epos  = '0;
		vacc  = '0;
	endfunction

	function ifed_pkg::result_t make_result(logic [15:0] id, logic [15:0] len,
			logic [31:0] val, logic [2:0] st);
		ifed_pkg::result_t r;
		r.meta_id       = id;
		r.entry_length  = len;
		r.value_word    = val;
		r.status        = st;
		r.unknown_total = unknown_cnt;
		r.last_in_run   = 1'b0;
		return r;
	endfunction

	// An entry is known only if its id fits the map and its enable bit is set.
	function bit id_enabled(logic [15:0] id);
		if (int'(id) >= ifed_pkg::ID_MAP_BITS || int'(id) >= 32)
			return 1'b0;
		return enables[id[4:0]];
	endfunction

	// Close the current entry and, if the region is used up, the region too.
	function void finish_entry();
		logic [2:0] st;
		st = ifed_pkg::ST_KNOWN;
		if (!id_enabled(etype)) begin
			unknown_cnt = unknown_cnt + 32'd1;
			st = ifed_pkg::ST_UNKNOWN;
		end
		step_out.push_back(make_result(etype, elen, vacc, st));
		clear_entry();
		if (region_left == 16'd0) begin
			step_out.push_back(make_result('0, '0, '0, ifed_pkg::ST_COMPLETE));
			phase = P_IDLE;
		end else begin
			phase = P_HDR;
		end
	endfunction

	// Parse one accepted byte and queue the results it should cause.
	function void note_byte(logic [7:0] b, logic first, logic last);
		logic [15:0] mlen;
		int vi;
		step_out.delete();
		if (first) begin
			phase = P_LEN_HI;
			region_left = '0;
			clear_entry();
		end
		if (phase != P_IDLE)
			parsed++;

		case (phase)
			P_LEN_HI: begin
				region_left = {b, 8'h00};
				phase = P_LEN_LO;
			end
			P_LEN_LO: begin
				mlen = region_left | {8'h00, b};
				if (mlen < 16'd2) begin
					region_left = '0;
					step_out.push_back(make_result('0, mlen, '0, ifed_pkg::ST_MALFORMED));
					phase = P_IDLE;
				end else begin
					region_left = mlen - 16'd2;
					clear_entry();
					if (region_left == 16'd0) begin
						step_out.push_back(make_result('0, '0, '0, ifed_pkg::ST_COMPLETE));
						phase = P_IDLE;
					end else begin
						phase = P_HDR;
					end
				end
			end
			P_HDR: begin
				region_left = region_left - 16'd1;
				case (epos[1:0])
					2'd0: etype = {b, 8'h00};
					2'd1: etype = etype | {8'h00, b};
					2'd2: elen  = {b, 8'h00};
					default: elen = elen | {8'h00, b};
				endcase
				epos = epos + 16'd1;
				if (epos >= 16'd4) begin
					if (elen < 16'd4 || int'(elen) - 4 > int'(region_left)) begin
						step_out.push_back(make_result(etype, elen, '0, ifed_pkg::ST_MALFORMED));
						phase = P_IDLE;
					end else if (elen == 16'd4) begin
						finish_entry();
					end else begin
						phase = P_VALUE;
					end
				end else if (region_left == 16'd0) begin
					// The region closed in the middle of an entry header.
					step_out.push_back(make_result(etype, elen, '0, ifed_pkg::ST_MALFORMED));
					phase = P_IDLE;
				end
			end
			P_VALUE: begin
				vi = int'(epos) - 4;
				region_left = region_left - 16'd1;
				if (vi < 4)
					vacc = vacc | (32'(b) << (24 - 8 * vi));
				epos = epos + 16'd1;
				if (epos == elen)
					finish_entry();
			end
			default: ;
		endcase

		// A frame that ends while the region is open is truncated.
		if (last && phase != P_IDLE) begin
			step_out.push_back(make_result('0, '0, '0, ifed_pkg::ST_TRUNCATED));
			phase = P_IDLE;
		end
		if (step_out.size() > 0)
			step_out[step_out.size() - 1].last_in_run = 1'b1;
		foreach (step_out[i]) want_q.push_back(step_out[i]);
	endfunction

	task report_mismatch(string msg);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t ERROR: %s", $time, msg);
	endtask

	// Compare one accepted result transaction with the oldest expectation.
	task check_result(ifed_pkg::result_t got);
		ifed_pkg::result_t want;
		if (want_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result: id %h len %h value %h status %0d",
				got.meta_id, got.entry_length, got.value_word, got.status));
			return;
		end
		want = want_q.pop_front();
		checked++;
		if (want.status <= ifed_pkg::ST_COMPLETE)
			by_status[want.status]++;
		if (got.meta_id !== want.meta_id)
			report_mismatch($sformatf("result %0d meta_id: got %h, want %h",
				checked, got.meta_id, want.meta_id));
		if (got.entry_length !== want.entry_length)
			report_mismatch($sformatf("result %0d entry_length: got %h, want %h",
				checked, got.entry_length, want.entry_length));
		if (got.value_word !== want.value_word)
			report_mismatch($sformatf("result %0d value_word: got %h, want %h",
				checked, got.value_word, want.value_word));
		if (got.status !== want.status)
			report_mismatch($sformatf("result %0d status: got %0d, want %0d",
				checked, got.status, want.status));
		if (got.unknown_total !== want.unknown_total)
			report_mismatch($sformatf("result %0d unknown_total: got %h, want %h",
				checked, got.unknown_total, want.unknown_total));
		if (got.last_in_run !== want.last_in_run)
			report_mismatch($sformatf("result %0d last_in_run: got %b, want %b",
				checked, got.last_in_run, want.last_in_run));
	endtask

endclass

module ife_metadata_tlv_deframer_top_tb;

	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 80;
	localparam int PHASE_BYTES   = 120;

	typedef struct packed {
		logic [7:0] b;
		logic       f;
		logic       l;
	} frame_byte_t;

	typedef enum logic [1:0] {
		SM_NONE,
		SM_COIN,
		SM_PERIODIC,
		SM_HEAVY
	} stall_mode_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        first_byte = 1'b0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] meta_id;
	logic [15:0] entry_length;
	logic [31:0] value_word;
	logic [2:0]  status;
	logic [31:0] unknown_total;
	logic        last_in_run;

	tlv_scoreboard sb;
	frame_byte_t   stream[$];
	logic [7:0]    body[$];
	int            burst_left = 0;
	int unsigned   bytes_sent = 0;
	int unsigned   frames = 0;
	int unsigned   cfg_writes = 0;
	bit            hold_req = 1'b0;
	bit            hold_active = 1'b0;

	ife_metadata_tlv_deframer_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.first_byte   (first_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.meta_id      (meta_id),
		.entry_length (entry_length),
		.value_word   (value_word),
		.status       (status),
		.unknown_total(unknown_total),
		.last_in_run  (last_in_run)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Generous upper bound on the whole run.
	initial begin : watchdog
		#4_000_000;
		$display("ife_metadata_tlv_deframer_top: mismatch");
		$finish;
	end

	// Check every result transaction taken by the receiver.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(ifed_pkg::result_t'{meta_id, entry_length, value_word, status,
				unknown_total, last_in_run});
	end

	// Receiver: stalls in patterns that change every so often, and holds off
	// completely for a long stretch when asked.
	initial begin : receiver
		stall_mode_e mode;
		int span;
		int period;
		int c;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				hold_active = 1'b1;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
				hold_active = 1'b0;
			end
			mode = stall_mode_e'($urandom_range(0, 3));
			span = $urandom_range(20, 150);
			period = $urandom_range(2, 5);
			for (c = 0; c < span && !hold_req; c++) begin
				@(negedge clk);
				case (mode)
					SM_NONE:     out_stall <= 1'b0;
					SM_COIN:     out_stall <= 1'($urandom_range(0, 1));
					SM_PERIODIC: out_stall <= ((c % period) == 0);
					default:     out_stall <= ($urandom_range(0, 4) != 0);
				endcase
			end
		end
	end

	function automatic void put(logic [7:0] b, logic f, logic l);
		frame_byte_t item;
		item.b = b;
		item.f = f;
		item.l = l;
		stream.push_back(item);
	endfunction

	function automatic logic [15:0] pick_type();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 16'($urandom_range(0, 40));
		if (r < 8)
			return 16'($urandom);
		return (r == 8) ? 16'd31 : 16'd32;
	endfunction

	// Append one entry header with the given length and some value bytes.
	function automatic void add_entry(logic [15:0] id, logic [15:0] len, int nval);
		body.push_back(id[15:8]);
		body.push_back(id[7:0]);
		body.push_back(len[15:8]);
		body.push_back(len[7:0]);
		repeat (nval) body.push_back(8'($urandom));
	endfunction

	// Build one frame: a metadata region that is mostly well formed, some
	// inner frame bytes, and now and then a broken region or plain noise.
	task automatic build_frame();
		frame_byte_t item;
		int kind;
		int nval;
		int extra;
		int cut;
		logic [15:0] mlen;
		body.delete();
		frames++;
		kind = $urandom_range(0, 99);
		if (kind >= 94) begin
			repeat ($urandom_range(1, 8))
				put(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
			return;
		end
		repeat ($urandom_range(0, 3)) begin
			nval = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
			add_entry(pick_type(), 16'(4 + nval), nval);
		end
		mlen = 16'(2 + body.size());
		if (kind >= 65 && kind < 72) begin
			// Entry length shorter than its own header.
			add_entry(pick_type(), 16'($urandom_range(0, 3)), 4);
			mlen = mlen + 16'd8;
		end else if (kind >= 72 && kind < 79) begin
			// Value bytes that would run past the region.
			nval = $urandom_range(1, 8);
			extra = ($urandom_range(0, 3) == 0) ? 16'hFFFF - 4 - nval : $urandom_range(1, 3);
			add_entry(pick_type(), 16'(4 + nval + extra), nval);
			mlen = mlen + 16'(4 + nval);
		end else if (kind >= 79 && kind < 85) begin
			// Region ends inside an entry header.
			add_entry(pick_type(), 16'($urandom_range(4, 12)), 0);
			mlen = mlen + 16'($urandom_range(1, 3));
		end else if (kind >= 85 && kind < 90) begin
			mlen = 16'($urandom_range(0, 1));
		end else if (kind >= 90) begin
			// Region longer than the frame, so it must be cut off.
			mlen = mlen + 16'($urandom_range(1, 40));
		end
		put(mlen[15:8], 1'b1, 1'b0);
		put(mlen[7:0], 1'b0, 1'b0);
		foreach (body[i]) put(body[i], 1'b0, 1'b0);
		repeat ($urandom_range(0, 4)) put(8'($urandom), 1'b0, 1'b0);
		if (kind >= 55 && kind < 65) begin
			cut = $urandom_range(1, stream.size() - 1);
			while (stream.size() > cut) void'(stream.pop_back());
		end
		if ($urandom_range(0, 9) != 0) begin
			item = stream.pop_back();
			item.l = 1'b1;
			stream.push_back(item);
		end
	endtask

	// Offer the queued bytes in bursts with random gaps between them.
	task automatic send_stream();
		frame_byte_t item;
		int gap;
		while (stream.size() > 0) begin
			item = stream.pop_front();
			@(negedge clk);
			in_valid   <= 1'b1;
			data_byte  <= item.b;
			first_byte <= item.f;
			last_byte  <= item.l;
			do @(posedge clk); while (in_stall);
			sb.note_byte(item.b, item.f, item.l);
			bytes_sent++;
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 24);
				if (!hold_active && $urandom_range(0, 3) != 0) begin
					gap = $urandom_range(1, 6);
					@(negedge clk);
					in_valid <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
			end
		end
	endtask

	// Stop sending and wait until every owed result has come out.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.want_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_enables(logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.enables = value;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [31:0] setting[5];
		int unsigned target;
		int p;
		sb = new();
		setting[0] = 32'h0000_0000;
		setting[1] = 32'hFFFF_FFFF;
		setting[2] = 32'h8000_0001;
		setting[3] = $urandom;
		setting[4] = $urandom;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed frames with types 1 and 2 enabled.
		write_enables(32'h0000_0006);
		// Length bytes with no first_byte straight after reset: empty region.
		put(8'h00, 1'b0, 1'b0);
		put(8'h02, 1'b0, 1'b0);
		// A byte after the region is ignored.
		put(8'hFF, 1'b0, 1'b0);
		// Metadata length of one.
		put(8'h00, 1'b1, 1'b0);
		put(8'h01, 1'b0, 1'b0);
		// Known entry with two value bytes, then an unknown empty entry that
		// closes the region on the frame's last byte.
		put(8'h00, 1'b1, 1'b0);
		put(8'h0C, 1'b0, 1'b0);
		put(8'h00, 1'b0, 1'b0);
		put(8'h01, 1'b0, 1'b0);
		put(8'h00, 1'b0, 1'b0);
		put(8'h06, 1'b0, 1'b0);
		put(8'hAA, 1'b0, 1'b0);
		put(8'hBB, 1'b0, 1'b0);
		put(8'hFF, 1'b0, 1'b0);
		put(8'hFF, 1'b0, 1'b0);
		put(8'h00, 1'b0, 1'b0);
		put(8'h04, 1'b0, 1'b1);
		// Entry length of three.
		put(8'h00, 1'b1, 1'b0);
		put(8'h08, 1'b0, 1'b0);
		put(8'h00, 1'b0, 1'b0);
		put(8'h02, 1'b0, 1'b0);
		put(8'h00, 1'b0, 1'b0);
		put(8'h03, 1'b0, 1'b0);
		// One-byte frame, then a frame cut off inside the first entry header.
		put(8'h12, 1'b1, 1'b1);
		put(8'hFF, 1'b1, 1'b0);
		put(8'hFF, 1'b0, 1'b0);
		put(8'h00, 1'b0, 1'b1);
		send_stream();
		drain_results();

		// Random frames under several enable settings; the second one also
		// gets a long receiver hold-off.
		for (p = 0; p < 5; p++) begin
			write_enables(setting[p]);
			if (p == 1)
				hold_req = 1'b1;
			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target) begin
				build_frame();
				send_stream();
			end
			drain_results();
		end
		repeat (16) @(posedge clk);

		$display("Sent %0d bytes (%0d parsed) in %0d frames under %0d id-enable settings.",
			bytes_sent, sb.parsed, frames, cfg_writes);
		$display("Checked %0d results: %0d known, %0d unknown, %0d malformed,",
			sb.checked, sb.by_status[ifed_pkg::ST_KNOWN],
			sb.by_status[ifed_pkg::ST_UNKNOWN], sb.by_status[ifed_pkg::ST_MALFORMED]);
		$display("  %0d truncated and %0d complete.",
			sb.by_status[ifed_pkg::ST_TRUNCATED], sb.by_status[ifed_pkg::ST_COMPLETE]);
		if (sb.mismatches == 0) begin
			$display("ife_metadata_tlv_deframer_top: match");
		end else begin
			$display("ife_metadata_tlv_deframer_top: mismatch");
		end
		$finish;
	end

endmodule
